FILE: hw/rtl/ptbr_pkg.sv
// Shared types and constants for the per-type batch range lists.
// Used by ptbr_pool and per_type_batch_range_lists; depends on nothing.
`default_nettype none

package ptbr_pkg;

  localparam int POOL_ENTRIES   = 1024;
  localparam int TYPE_COUNT     = 8;
  localparam int INSTANCE_SPACE = 32768;

  localparam int SLOT_W = $clog2(POOL_ENTRIES);
  localparam int TYPE_W = $clog2(TYPE_COUNT);

  typedef logic [SLOT_W-1:0] slot_t;
  typedef logic [SLOT_W:0]   used_t;

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_ADD   = 2'd1,
    OP_READ  = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_DONE        = 3'd0,
    ST_IGNORED     = 3'd1,
    ST_HEAD_FILLED = 3'd2,
    ST_EXTENDED    = 3'd3,
    ST_NEW_ENTRY   = 3'd4,
    ST_POOL_FULL   = 3'd5,
    ST_REJECTED    = 3'd6
  } status_t;

  typedef struct packed {
    logic  last;
    slot_t slot;
  } link_t;

  typedef struct packed {
    logic        start_we;
    logic        end_we;
    slot_t       wr_addr;
    logic [14:0] wr_start;
    logic [15:0] wr_end;
    logic        link_we;
    slot_t       link_addr;
    link_t       link_data;
    logic        rd_en;
    slot_t       rd_addr;
  } pool_req_t;

  typedef struct packed {
    status_t     status;
    slot_t       entry_slot;
    logic [14:0] entry_start;
    logic [15:0] entry_end;
    slot_t       next_slot;
    logic        list_end;
    logic        head_empty;
    logic        pool_read;
  } result_t;

endpackage

`default_nettype wire

FILE: hw/rtl/ptbr_pool.sv
// Shared entry pool: range start, range end and link memories.
// One write address per memory, registered read. Depends on ptbr_pkg.
`default_nettype none

module ptbr_pool (
  input  wire                      clk,
  input  wire ptbr_pkg::pool_req_t req,
  output logic [14:0]              rd_start,
  output logic [15:0]              rd_end,
  output ptbr_pkg::link_t          rd_link
);

  logic [14:0]     start_mem [ptbr_pkg::POOL_ENTRIES];
  logic [15:0]     end_mem   [ptbr_pkg::POOL_ENTRIES];
  ptbr_pkg::link_t link_mem  [ptbr_pkg::POOL_ENTRIES];

  always_ff @(posedge clk) begin
    if (req.start_we) begin
      start_mem[req.wr_addr] <= req.wr_start;
    end
    if (req.rd_en) begin
      rd_start <= start_mem[req.rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (req.end_we) begin
      end_mem[req.wr_addr] <= req.wr_end;
    end
    if (req.rd_en) begin
      rd_end <= end_mem[req.rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (req.link_we) begin
      link_mem[req.link_addr] <= req.link_data;
    end
    if (req.rd_en) begin
      rd_link <= link_mem[req.rd_addr];
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/per_type_batch_range_lists.sv
// Per-type batch range lists: one linked list of instance ranges per render type.
// Requests pass the registers q, s1 and out; one request per cycle while the output
// is not back-pressured and no sweep runs. After a clear, the old pool tails get
// their end marks through the single link-memory write port; requests wait meanwhile.
// Reset (rst, synchronous): all heads empty, tails on heads, pool count zero;
// pool memory is not cleared. Depends on ptbr_pkg and ptbr_pool.
`default_nettype none

module per_type_batch_range_lists (
  input  wire         clk,
  input  wire         rst,
  input  wire         s_tvalid,
  output logic        s_tready,
  // batch_type[2:0], range_start[17:3], range_count[33:18], entry_index[43:34]
  input  wire  [47:0] s_tdata,
  // operation[1:0], read_head[2]
  input  wire  [2:0]  s_tuser,
  output logic        m_tvalid,
  input  wire         m_tready,
  // status[2:0], entry_slot[12:3], entry_start[27:13], entry_end[43:28],
  // next_slot[53:44], list_end[54], head_empty[55]
  output logic [55:0] m_tdata
);

  localparam int TC = ptbr_pkg::TYPE_COUNT;
  localparam int TW = ptbr_pkg::TYPE_W;

  typedef enum logic [1:0] {
    PH_RUN   = 2'b01,
    PH_SWEEP = 2'b10
  } phase_t;

  logic                q_valid;
  ptbr_pkg::op_t       q_op;
  logic                q_head;
  logic [2:0]          q_type;
  logic [14:0]         q_start;
  logic [15:0]         q_count;
  ptbr_pkg::slot_t     q_idx;

  logic                s1_valid;
  ptbr_pkg::result_t   s1;
  logic                out_valid;
  logic [55:0]         out_data;

  logic [TC-1:0]       head_unused;
  logic [14:0]         head_start  [TC];
  logic [15:0]         head_end    [TC];
  logic [TC-1:0]       head_linked;
  ptbr_pkg::slot_t     head_next   [TC];
  logic [TC-1:0]       tail_in_pool;
  ptbr_pkg::slot_t     tail_slot   [TC];
  logic [15:0]         tail_end    [TC];
  ptbr_pkg::used_t     entries_used;
  phase_t              phase;
  logic [TW-1:0]       sweep_cnt;

  logic                out_en;
  logic                s1_en;
  logic                proc;
  logic [TW-1:0]       ti;
  logic [16:0]         sum;
  logic [15:0]         end16;
  logic                type_ok;
  logic                range_ok;
  logic                idx_ok;
  logic                pool_full;
  ptbr_pkg::slot_t     new_slot;
  logic                tail_hit;
  logic                tail_match;
  logic                act_fill;
  logic                act_ext;
  logic                act_new;
  ptbr_pkg::result_t   res;
  ptbr_pkg::pool_req_t preq;
  logic [14:0]         rd_start;
  logic [15:0]         rd_end;
  ptbr_pkg::link_t     rd_link;
  logic                fin_end;
  logic [14:0]         fin_start;
  logic [15:0]         fin_stop;
  ptbr_pkg::slot_t     fin_next;

  assign out_en   = !out_valid || m_tready;
  assign s1_en    = !s1_valid || out_en;
  assign proc     = q_valid && s1_en && (phase == PH_RUN);
  assign s_tready = !q_valid || proc;
  assign m_tvalid = out_valid;
  assign m_tdata  = out_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid <= 1'b0;
    end else if (s_tready) begin
      q_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      q_op    <= ptbr_pkg::op_t'(s_tuser[1:0]);
      q_head  <= s_tuser[2];
      q_type  <= s_tdata[2:0];
      q_start <= s_tdata[17:3];
      q_count <= s_tdata[33:18];
      q_idx   <= s_tdata[43:34];
    end
  end

  assign ti        = q_type[TW-1:0];
  assign sum       = {2'b00, q_start} + {1'b0, q_count};
  assign end16     = sum[15:0];
  assign type_ok   = int'(q_type) < TC;
  assign range_ok  = sum <= 17'(ptbr_pkg::INSTANCE_SPACE);
  assign idx_ok    = int'(q_idx) < ptbr_pkg::POOL_ENTRIES;
  assign pool_full = entries_used >= ptbr_pkg::used_t'(ptbr_pkg::POOL_ENTRIES);
  assign new_slot  = entries_used[ptbr_pkg::SLOT_W-1:0];
  assign tail_hit  = tail_end[ti] == {1'b0, q_start};

  always_comb begin
    tail_match = 1'b0;
    for (int t = 0; t < TC; t++) begin
      if (tail_in_pool[t] && (tail_slot[t] == q_idx)) begin
        tail_match = 1'b1;
      end
    end
  end

  always_comb begin
    res        = '0;
    res.status = ptbr_pkg::ST_DONE;
    act_fill   = 1'b0;
    act_ext    = 1'b0;
    act_new    = 1'b0;
    case (q_op)
      ptbr_pkg::OP_ADD: begin
        if (q_count == '0) begin
          res.status = ptbr_pkg::ST_IGNORED;
        end else if (!type_ok || !range_ok) begin
          res.status = ptbr_pkg::ST_REJECTED;
        end else if (head_unused[ti]) begin
          res.status = ptbr_pkg::ST_HEAD_FILLED;
          act_fill   = 1'b1;
        end else if (tail_hit) begin
          res.status = ptbr_pkg::ST_EXTENDED;
          act_ext    = 1'b1;
          if (tail_in_pool[ti]) begin
            res.entry_slot = tail_slot[ti];
          end
        end else if (pool_full) begin
          res.status = ptbr_pkg::ST_POOL_FULL;
        end else begin
          res.status     = ptbr_pkg::ST_NEW_ENTRY;
          res.entry_slot = new_slot;
          act_new        = 1'b1;
        end
      end
      ptbr_pkg::OP_READ: begin
        if (q_head) begin
          if (!type_ok) begin
            res.status = ptbr_pkg::ST_REJECTED;
          end else begin
            res.entry_start = head_start[ti];
            res.entry_end   = head_end[ti];
            res.next_slot   = head_linked[ti] ? head_next[ti] : '0;
            res.list_end    = !head_linked[ti];
            res.head_empty  = head_unused[ti];
          end
        end else if (!idx_ok) begin
          res.status = ptbr_pkg::ST_REJECTED;
        end else begin
          res.pool_read  = 1'b1;
          res.entry_slot = q_idx;
          res.list_end   = tail_match;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    preq          = '0;
    preq.start_we = proc && act_new;
    preq.end_we   = proc && (act_new || (act_ext && tail_in_pool[ti]));
    preq.wr_addr  = act_new ? new_slot : tail_slot[ti];
    preq.wr_start = q_start;
    preq.wr_end   = end16;
    preq.rd_en    = proc && (q_op == ptbr_pkg::OP_READ) && !q_head;
    preq.rd_addr  = q_idx;
    if (phase == PH_SWEEP) begin
      preq.link_we        = tail_in_pool[sweep_cnt];
      preq.link_addr      = tail_slot[sweep_cnt];
      preq.link_data.last = 1'b1;
      preq.link_data.slot = '0;
    end else begin
      preq.link_we        = proc && act_new && tail_in_pool[ti];
      preq.link_addr      = tail_slot[ti];
      preq.link_data.last = 1'b0;
      preq.link_data.slot = new_slot;
    end
  end

  ptbr_pool u_pool (
    .clk      (clk),
    .req      (preq),
    .rd_start (rd_start),
    .rd_end   (rd_end),
    .rd_link  (rd_link)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      head_unused  <= '1;
      head_linked  <= '0;
      tail_in_pool <= '0;
      entries_used <= '0;
      phase        <= PH_RUN;
      sweep_cnt    <= '0;
      for (int t = 0; t < TC; t++) begin
        head_start[t] <= '0;
        head_end[t]   <= '0;
        head_next[t]  <= '0;
        tail_slot[t]  <= '0;
        tail_end[t]   <= '0;
      end
    end else begin
      if (proc) begin
        case (q_op)
          ptbr_pkg::OP_CLEAR: begin
            head_unused  <= '1;
            head_linked  <= '0;
            entries_used <= '0;
            phase        <= PH_SWEEP;
            sweep_cnt    <= '0;
            for (int t = 0; t < TC; t++) begin
              head_start[t] <= '0;
              head_end[t]   <= '0;
            end
          end
          ptbr_pkg::OP_ADD: begin
            if (act_fill) begin
              head_unused[ti] <= 1'b0;
              head_start[ti]  <= q_start;
              head_end[ti]    <= end16;
              head_linked[ti] <= 1'b0;
              tail_end[ti]    <= end16;
            end
            if (act_ext) begin
              tail_end[ti] <= end16;
              if (!tail_in_pool[ti]) begin
                head_end[ti] <= end16;
              end
            end
            if (act_new) begin
              if (!tail_in_pool[ti]) begin
                head_linked[ti] <= 1'b1;
                head_next[ti]   <= new_slot;
              end
              tail_in_pool[ti] <= 1'b1;
              tail_slot[ti]    <= new_slot;
              tail_end[ti]     <= end16;
              entries_used     <= entries_used + 1'b1;
            end
          end
          default: begin
          end
        endcase
      end
      if (phase == PH_SWEEP) begin
        tail_in_pool[sweep_cnt] <= 1'b0;
        tail_slot[sweep_cnt]    <= '0;
        if (sweep_cnt == TW'(TC - 1)) begin
          phase <= PH_RUN;
        end else begin
          sweep_cnt <= sweep_cnt + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_en) begin
      s1_valid <= proc;
    end
  end

  always_ff @(posedge clk) begin
    if (proc) begin
      s1 <= res;
    end
  end

  assign fin_end   = s1.list_end || (s1.pool_read && rd_link.last);
  assign fin_start = s1.pool_read ? rd_start : s1.entry_start;
  assign fin_stop  = s1.pool_read ? rd_end : s1.entry_end;
  assign fin_next  = s1.pool_read ? (fin_end ? '0 : rd_link.slot) : s1.next_slot;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_en) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_en && s1_valid) begin
      out_data <= {s1.head_empty, fin_end, fin_next, fin_stop, fin_start,
                   s1.entry_slot, s1.status};
    end
  end

`ifndef SYNTHESIS
  a_used_bound: assert property (@(posedge clk) disable iff (rst)
    entries_used <= ptbr_pkg::used_t'(ptbr_pkg::POOL_ENTRIES))
    else $error("pool count beyond pool size");

  a_clear_sweep: assert property (@(posedge clk) disable iff (rst)
    proc && (q_op == ptbr_pkg::OP_CLEAR) |=> (phase == PH_SWEEP) && (entries_used == '0))
    else $error("clear did not start tail sweep");

  a_new_count: assert property (@(posedge clk) disable iff (rst)
    proc && act_new |=> entries_used == $past(entries_used) + 1'b1)
    else $error("new entry did not advance pool count");

  a_fill_head: assert property (@(posedge clk) disable iff (rst)
    proc && act_fill |=> !head_unused[$past(ti)])
    else $error("head fill left head empty");
`endif

endmodule

`default_nettype wire

FILE: test/tb_per_type_batch_range_lists.sv
// Self-checking bench for per_type_batch_range_lists: directed list building,
// then random add/read/clear traffic checked against an in-bench list predictor.
// Depends on ptbr_pkg and the per_type_batch_range_lists RTL.
module tb_per_type_batch_range_lists;

  localparam int TIMEOUT_CYCLES = 200000;
  localparam int HOLD_AT = 400;
  localparam int HOLD_LEN = 300;

  typedef enum logic [1:0] {
    AS_GIVEN,
    FOLLOW_TAIL,
    WRITTEN_ENTRY
  } pick_t;

  typedef struct {
    ptbr_pkg::op_t   op;
    logic [2:0]      btype;
    logic [14:0]     range_lo;
    logic [15:0]     range_n;
    logic            head;
    ptbr_pkg::slot_t index;
    pick_t           pick;
  } request_t;

  // packed from the top bit of m_tdata down
  typedef struct packed {
    logic              head_empty;
    logic              list_end;
    ptbr_pkg::slot_t   next_slot;
    logic [15:0]       entry_end;
    logic [14:0]       entry_start;
    ptbr_pkg::slot_t   entry_slot;
    ptbr_pkg::status_t status;
  } answer_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [47:0] s_tdata = '0;
  logic [2:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [55:0] m_tdata;

  request_t request_q[$];
  answer_t  answer_q[$];
  request_t on_bus;
  answer_t  got;
  answer_t  want;
  int       sent = 0;
  int       rx_cycle = 0;
  int       mismatches = 0;

  logic            head_free [ptbr_pkg::TYPE_COUNT];
  logic [14:0]     head_lo [ptbr_pkg::TYPE_COUNT];
  logic [15:0]     head_hi [ptbr_pkg::TYPE_COUNT];
  ptbr_pkg::link_t head_next [ptbr_pkg::TYPE_COUNT];
  logic            tail_pooled [ptbr_pkg::TYPE_COUNT];
  ptbr_pkg::slot_t tail_idx [ptbr_pkg::TYPE_COUNT];
  logic [14:0]     pool_lo [ptbr_pkg::POOL_ENTRIES];
  logic [15:0]     pool_hi [ptbr_pkg::POOL_ENTRIES];
  ptbr_pkg::link_t pool_next [ptbr_pkg::POOL_ENTRIES];
  ptbr_pkg::used_t used;
  int              pool_high;

  per_type_batch_range_lists uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  function automatic void empty_lists();
    for (int t = 0; t < ptbr_pkg::TYPE_COUNT; t++) begin
      head_free[t] = 1'b1;
      head_lo[t] = '0;
      head_hi[t] = '0;
      head_next[t].last = 1'b1;
      head_next[t].slot = '0;
      tail_pooled[t] = 1'b0;
      tail_idx[t] = '0;
    end
    used = '0;
  endfunction

  function automatic answer_t apply_request(request_t r);
    answer_t         a;
    ptbr_pkg::link_t lk;
    logic [16:0]     span;
    ptbr_pkg::slot_t s;
    a = '0;
    a.status = ptbr_pkg::ST_DONE;
    span = {2'b00, r.range_lo} + {1'b0, r.range_n};
    case (r.op)
      ptbr_pkg::OP_CLEAR: empty_lists();
      ptbr_pkg::OP_ADD: begin
        if (r.range_n == 0) begin
          a.status = ptbr_pkg::ST_IGNORED;
        end else if (span > ptbr_pkg::INSTANCE_SPACE) begin
          a.status = ptbr_pkg::ST_REJECTED;
        end else if (head_free[r.btype]) begin
          head_free[r.btype] = 1'b0;
          head_lo[r.btype] = r.range_lo;
          head_hi[r.btype] = span[15:0];
          head_next[r.btype].last = 1'b1;
          head_next[r.btype].slot = '0;
          a.status = ptbr_pkg::ST_HEAD_FILLED;
        end else if (tail_pooled[r.btype] && pool_hi[tail_idx[r.btype]] == r.range_lo) begin
          pool_hi[tail_idx[r.btype]] = span[15:0];
          a.entry_slot = tail_idx[r.btype];
          a.status = ptbr_pkg::ST_EXTENDED;
        end else if (!tail_pooled[r.btype] && head_hi[r.btype] == r.range_lo) begin
          head_hi[r.btype] = span[15:0];
          a.status = ptbr_pkg::ST_EXTENDED;
        end else if (used == ptbr_pkg::POOL_ENTRIES) begin
          a.status = ptbr_pkg::ST_POOL_FULL;
        end else begin
          s = used[ptbr_pkg::SLOT_W-1:0];
          pool_lo[s] = r.range_lo;
          pool_hi[s] = span[15:0];
          pool_next[s].last = 1'b1;
          pool_next[s].slot = '0;
          if (tail_pooled[r.btype]) begin
            pool_next[tail_idx[r.btype]].last = 1'b0;
            pool_next[tail_idx[r.btype]].slot = s;
          end else begin
            head_next[r.btype].last = 1'b0;
            head_next[r.btype].slot = s;
          end
          tail_pooled[r.btype] = 1'b1;
          tail_idx[r.btype] = s;
          used = used + 1'b1;
          if (used > pool_high) pool_high = int'(used);
          a.entry_slot = s;
          a.status = ptbr_pkg::ST_NEW_ENTRY;
        end
      end
      ptbr_pkg::OP_READ: begin
        if (r.head) begin
          lk = head_next[r.btype];
          a.entry_start = head_lo[r.btype];
          a.entry_end = head_hi[r.btype];
          a.head_empty = head_free[r.btype];
        end else begin
          lk = pool_next[r.index];
          a.entry_slot = r.index;
          a.entry_start = pool_lo[r.index];
          a.entry_end = pool_hi[r.index];
        end
        a.list_end = lk.last;
        a.next_slot = lk.last ? '0 : lk.slot;
      end
      default: ;
    endcase
    return a;
  endfunction

  // aim chained adds at the current tail end, pool reads at written entries only
  function automatic request_t bind_to_state(request_t r);
    logic [16:0] tail_end;
    tail_end = {1'b0, (tail_pooled[r.btype] ? pool_hi[tail_idx[r.btype]] : head_hi[r.btype])};
    if (r.pick == FOLLOW_TAIL && !head_free[r.btype] && tail_end < ptbr_pkg::INSTANCE_SPACE) begin
      r.range_lo = tail_end[14:0];
      if (tail_end + r.range_n > ptbr_pkg::INSTANCE_SPACE)
        r.range_n = 16'(ptbr_pkg::INSTANCE_SPACE - tail_end);
    end
    if (r.pick == WRITTEN_ENTRY && !r.head) begin
      if (pool_high == 0) r.head = 1'b1;
      else r.index = ptbr_pkg::slot_t'(r.index % pool_high);
    end
    return r;
  endfunction

  function automatic request_t mk_req(ptbr_pkg::op_t op, int btype, int lo, int n, bit head,
                                      int idx);
    request_t r;
    r.op = op;
    r.btype = 3'(btype);
    r.range_lo = 15'(lo);
    r.range_n = 16'(n);
    r.head = head;
    r.index = ptbr_pkg::slot_t'(idx);
    r.pick = AS_GIVEN;
    return r;
  endfunction

  task automatic push_random(int n, bit filling);
    request_t r;
    int       roll;
    int       sub;
    for (int i = 0; i < n; i++) begin
      r.op = ptbr_pkg::OP_ADD;
      r.btype = 3'($urandom_range(0, 7));
      r.range_n = 16'($urandom_range(1, 64));
      r.range_lo = 15'($urandom_range(0, ptbr_pkg::INSTANCE_SPACE - r.range_n));
      r.head = 1'($urandom_range(0, 1));
      r.index = ptbr_pkg::slot_t'($urandom_range(0, ptbr_pkg::POOL_ENTRIES - 1));
      r.pick = AS_GIVEN;
      roll = $urandom_range(0, 99);
      if (filling) begin
        if (roll < 5) begin
          r.op = ptbr_pkg::OP_READ;
          r.pick = WRITTEN_ENTRY;
        end
      end else if (roll < 2) begin
        r.op = ptbr_pkg::OP_CLEAR;
      end else if (roll < 4) begin
        r.op = ptbr_pkg::OP_NONE;
      end else if (roll < 34) begin
        r.op = ptbr_pkg::OP_READ;
        r.pick = WRITTEN_ENTRY;
      end else begin
        sub = $urandom_range(0, 99);
        if (sub < 45) begin
          r.pick = FOLLOW_TAIL;
        end else if (sub < 50) begin
          r.range_n = '0;
        end else if (sub < 55) begin
          r.range_n = 16'($urandom_range(0, 65535));
        end else if (sub < 65) begin
          r.range_n = 16'($urandom_range(1, ptbr_pkg::INSTANCE_SPACE));
          r.range_lo = 15'($urandom_range(0, ptbr_pkg::INSTANCE_SPACE - r.range_n));
        end
      end
      request_q.push_back(r);
    end
  endtask

  function automatic string show(answer_t a);
    return $sformatf("status=%0d slot=%0d start=%0d end=%0d next=%0d last=%0b empty=%0b",
                     a.status, a.entry_slot, a.entry_start, a.entry_end, a.next_slot,
                     a.list_end, a.head_empty);
  endfunction

  task automatic note_mismatch(string what, answer_t exp_a, answer_t act_a);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%0t %s", $time, what);
      $display("  expected %s", show(exp_a));
      $display("  actual   %s", show(act_a));
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) answer_q.push_back(apply_request(on_bus));
      if (!s_tvalid || s_tready) begin
        if (request_q.size() != 0 &&
            ((sent >= 500 && sent < 750) || $urandom_range(0, 99) >= 14)) begin
          on_bus = bind_to_state(request_q.pop_front());
          s_tdata <= {4'b0, on_bus.index, on_bus.range_n, on_bus.range_lo, on_bus.btype};
          s_tuser <= {on_bus.head, on_bus.op};
          s_tvalid <= 1'b1;
          sent = sent + 1;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // hold off once for a long stretch so the block backs up into its input
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      rx_cycle <= rx_cycle + 1;
      if (rx_cycle >= HOLD_AT && rx_cycle < HOLD_AT + HOLD_LEN) begin
        m_tready <= 1'b0;
      end else if (rx_cycle >= 1100 && rx_cycle < 1400) begin
        m_tready <= 1'b1;
      end else begin
        m_tready <= ($urandom_range(0, 99) >= 14);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      got = answer_t'(m_tdata);
      if (answer_q.size() == 0) begin
        note_mismatch("result with no request pending", '0, got);
      end else begin
        want = answer_q.pop_front();
        if (got.status !== want.status || got.entry_slot !== want.entry_slot ||
            got.entry_start !== want.entry_start || got.entry_end !== want.entry_end ||
            got.next_slot !== want.next_slot || got.list_end !== want.list_end ||
            got.head_empty !== want.head_empty)
          note_mismatch("result differs", want, got);
      end
    end
  end

  initial begin
    empty_lists();
    pool_high = 0;

    request_q.push_back(mk_req(ptbr_pkg::OP_NONE, 5, 1234, 7, 1, 77));
    request_q.push_back(mk_req(ptbr_pkg::OP_READ, 0, 0, 0, 1, 0));
    request_q.push_back(mk_req(ptbr_pkg::OP_ADD, 0, 0, 32768, 0, 0));
    request_q.push_back(mk_req(ptbr_pkg::OP_ADD, 1, 1, 32768, 0, 0));
    request_q.push_back(mk_req(ptbr_pkg::OP_ADD, 1, 32767, 1, 0, 0));
    request_q.push_back(mk_req(ptbr_pkg::OP_ADD, 1, 5, 0, 0, 0));
    request_q.push_back(mk_req(ptbr_pkg::OP_ADD, 1, 100, 65535, 1, 1023));
    request_q.push_back(mk_req(ptbr_pkg::OP_ADD, 2, 10, 5, 0, 0));
    request_q.push_back(mk_req(ptbr_pkg::OP_ADD, 2, 15, 5, 0, 0));
    request_q.push_back(mk_req(ptbr_pkg::OP_ADD, 2, 40, 8, 0, 0));
    request_q.push_back(mk_req(ptbr_pkg::OP_ADD, 2, 48, 2, 0, 0));
    request_q.push_back(mk_req(ptbr_pkg::OP_ADD, 3, 0, 1, 0, 0));
    request_q.push_back(mk_req(ptbr_pkg::OP_ADD, 3, 7, 1, 0, 0));
    request_q.push_back(mk_req(ptbr_pkg::OP_ADD, 2, 1000, 3, 0, 0));
    request_q.push_back(mk_req(ptbr_pkg::OP_READ, 2, 0, 0, 1, 0));
    request_q.push_back(mk_req(ptbr_pkg::OP_READ, 6, 0, 0, 0, 0));
    request_q.push_back(mk_req(ptbr_pkg::OP_READ, 1, 0, 0, 0, 2));
    request_q.push_back(mk_req(ptbr_pkg::OP_READ, 7, 0, 0, 1, 0));
    request_q.push_back(mk_req(ptbr_pkg::OP_ADD, 7, 32000, 768, 0, 0));
    request_q.push_back(mk_req(ptbr_pkg::OP_ADD, 7, 0, 1, 0, 0));
    request_q.push_back(mk_req(ptbr_pkg::OP_READ, 7, 0, 0, 1, 0));
    request_q.push_back(mk_req(ptbr_pkg::OP_CLEAR, 4, 321, 9, 1, 512));
    request_q.push_back(mk_req(ptbr_pkg::OP_READ, 2, 0, 0, 1, 0));
    request_q.push_back(mk_req(ptbr_pkg::OP_READ, 0, 0, 0, 0, 1));
    request_q.push_back(mk_req(ptbr_pkg::OP_ADD, 2, 32767, 1, 0, 0));

    // drive the pool into exhaustion, then mixed traffic with clears
    push_random(1130, 1'b1);
    push_random(150, 1'b0);

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    @(negedge clk);
    while (request_q.size() != 0 || s_tvalid || answer_q.size() != 0) @(negedge clk);
    repeat (16) @(posedge clk);

    if (mismatches == 0 && answer_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_CYCLES * 8);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

FILE: files.f
hw/rtl/ptbr_pkg.sv
hw/rtl/ptbr_pool.sv
hw/rtl/per_type_batch_range_lists.sv
test/tb_per_type_batch_range_lists.sv
